### src/lpdp_pkg.sv
// lpdp_pkg: shared types and constants for the local peak detector.
// Holds the sequencer state type, the register index codes and the fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpdp_pkg;

    // Fixed field widths
    localparam int MIN_AMP_W  = 15;
    localparam int GUARD_W    = 10;
    localparam int PERIOD_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 9;
    localparam int TIME_W     = 56;

    // Q8 position and shared adder width (product kept modulo 2^64)
    localparam int Q_SHIFT    = 8;
    localparam int ACC_W      = 64;
    localparam int DIGIT_W    = 8;

    // Divider: quotient is at most 128, so eight restoring steps
    localparam int QUOT_W     = 8;
    localparam int STEP_W     = 3;
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = 3'd7;
    localparam logic [QUOT_W-1:0] FRAC_HALF     = 8'd128;

    // Register reset values
    localparam logic [MIN_AMP_W-1:0] MIN_AMP_RST = 15'd0;
    localparam logic [GUARD_W-1:0]   GUARD_RST   = 10'd5;
    localparam logic [GUARD_W-1:0]   GUARD_MIN   = 10'd1;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 32'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

    // History fill level once two samples are held
    localparam logic [1:0] FILL_FULL = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_POS  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### src/local_peak_detector_parabolic.sv
// Local peak detector with parabolic sub-sample refinement (top level).
// Sequencing: a sample that gives no peak is taken while idle. A peak runs 8 divide
// steps, 1 position step, ceil((INDEX_BITS+8)/8) multiply steps (4 by default) and
// 1 output load, which waits while the output stalls; divide and multiply share one 64-bit add/subtract unit.
// Throughput: one beat at a time; in_stall is high while a peak is being refined or waits for the output.
// Reset: asynchronous, clears history, count, sequencer, output valid and configuration registers to defaults.
// Depends on lpdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module local_peak_detector_parabolic
    import lpdp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          series_start,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [INDEX_BITS-1:0]              peak_index,
    output logic signed [FRAC_W-1:0]           peak_fraction,
    output logic [TIME_W-1:0]                  peak_time
);

    localparam int DIV_W     = SAMPLE_BITS + 9;
    localparam int POS_W     = INDEX_BITS + Q_SHIFT;
    localparam int DIGITS    = (POS_W + DIGIT_W - 1) / DIGIT_W;
    localparam int POS_PAD_W = DIGITS * DIGIT_W;
    localparam int CMP_W     = (INDEX_BITS > GUARD_W) ? INDEX_BITS : GUARD_W;

    // Configuration registers
    logic [MIN_AMP_W-1:0] min_amp_reg;
    logic [GUARD_W-1:0]   guard_reg;
    logic [PERIOD_W-1:0]  period_reg;

    // History
    logic signed [SAMPLE_BITS-1:0] older_reg, older_next;
    logic signed [SAMPLE_BITS-1:0] middle_reg, middle_next;
    logic [INDEX_BITS-1:0]         count_reg, count_next;
    logic [1:0]                    fill_reg, fill_next;

    // Sequencer and datapath
    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       den_reg, den_next;
    logic [QUOT_W-1:0]      quot_reg, quot_next;
    logic                   neg_reg, neg_next;
    logic [INDEX_BITS-1:0]  idx_reg, idx_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [POS_PAD_W-1:0]   pos_reg, pos_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]  out_idx_reg, out_idx_next;
    logic [FRAC_W-1:0]      out_frac_reg, out_frac_next;
    logic [TIME_W-1:0]      out_time_reg, out_time_next;

    // Accept-cycle signals
    logic                          in_fire;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] cur_old, cur_mid;
    logic [INDEX_BITS-1:0]         cur_cnt, cur_idx;
    logic [1:0]                    cur_fill;
    logic [GUARD_W-1:0]            guard_eff;
    logic signed [MIN_AMP_W:0]     min_amp_s;
    logic signed [SAMPLE_BITS:0]   d_old, d_new;
    logic [SAMPLE_BITS:0]          mag_a;
    logic [SAMPLE_BITS-1:0]        mag_b;
    logic                          b_pos;
    logic                          is_peak;

    // Position step and multiply signals
    logic [QUOT_W-1:0]             quot_clamp;
    logic [FRAC_W-1:0]             frac_val;
    logic [POS_W-1:0]              pos_val;
    logic [DIGIT_W-1:0]            digit;
    logic [DIGIT_W+PERIOD_W-1:0]   prod;

    // Shared add/subtract unit
    logic [ACC_W-1:0]  add_a, add_b;
    logic              add_sub;
    logic [ACC_W:0]    add_res;
    logic              div_ge;

    assign in_stall      = (state_reg != ST_IDLE);
    assign in_fire       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign peak_index    = out_idx_reg;
    assign peak_fraction = out_frac_reg;
    assign peak_time     = out_time_reg;

    // Peak test on the accepted beat; a series start clears history first
    always_comb
    begin
        cur_old   = series_start ? '0 : older_reg;
        cur_mid   = series_start ? '0 : middle_reg;
        cur_cnt   = series_start ? '0 : count_reg;
        cur_fill  = series_start ? '0 : fill_reg;
        cur_idx   = cur_cnt - INDEX_BITS'(1);
        guard_eff = (guard_reg == '0) ? GUARD_MIN : guard_reg;
        min_amp_s = {1'b0, min_amp_reg};
        d_old     = {cur_mid[SAMPLE_BITS-1], cur_mid} - {cur_old[SAMPLE_BITS-1], cur_old};
        d_new     = {cur_mid[SAMPLE_BITS-1], cur_mid} - {sample[SAMPLE_BITS-1], sample};
        // both differences are positive for a peak, so their low bits are magnitudes
        mag_a     = {1'b0, d_old[SAMPLE_BITS-1:0]} + {1'b0, d_new[SAMPLE_BITS-1:0]};
        b_pos     = (d_new[SAMPLE_BITS-1:0] > d_old[SAMPLE_BITS-1:0]);
        mag_b     = b_pos ? (d_new[SAMPLE_BITS-1:0] - d_old[SAMPLE_BITS-1:0])
                          : (d_old[SAMPLE_BITS-1:0] - d_new[SAMPLE_BITS-1:0]);
        is_peak   = (cur_fill == FILL_FULL)
                  && (CMP_W'(cur_idx) > CMP_W'(guard_eff))
                  && (cur_mid > min_amp_s)
                  && (cur_mid > cur_old)
                  && (cur_mid > sample);
    end

    // Position step: clamp, apply sign, build Q8 position; also the multiply digit and product
    always_comb
    begin
        quot_clamp = (quot_reg > FRAC_HALF) ? FRAC_HALF : quot_reg;
        frac_val   = neg_reg ? (FRAC_W'(0) - {1'b0, quot_clamp}) : {1'b0, quot_clamp};
        pos_val    = (POS_W'(idx_reg) << Q_SHIFT)
                   + {{(POS_W-FRAC_W){frac_val[FRAC_W-1]}}, frac_val};
        digit      = pos_reg[POS_PAD_W-1 -: DIGIT_W];
        prod       = digit * period_reg;
    end

    // Shared unit: restoring subtract while dividing, shift-accumulate while multiplying
    always_comb
    begin
        add_a   = ACC_W'(rem_reg);
        add_b   = ACC_W'(den_reg);
        add_sub = 1'b1;
        if (state_reg == ST_MUL)
        begin
            add_a   = acc_reg << DIGIT_W;
            add_b   = ACC_W'(prod);
            add_sub = 1'b0;
        end
        add_res = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
                + (ACC_W+1)'(add_sub);
        div_ge  = !add_res[ACC_W];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        frac_next      = frac_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        older_next     = older_reg;
        middle_next    = middle_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_frac_next  = out_frac_reg;
        out_time_next  = out_time_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    older_next  = cur_mid;
                    middle_next = sample;
                    count_next  = cur_cnt + INDEX_BITS'(1);
                    fill_next   = (cur_fill == FILL_FULL) ? FILL_FULL : cur_fill + 2'd1;
                    if (is_peak)
                    begin
                        // numerator 256*|b| + |a|, divisor 2*|a| aligned to quotient bit 7
                        rem_next   = (DIV_W'(mag_b) << Q_SHIFT) + DIV_W'(mag_a);
                        den_next   = DIV_W'(mag_a) << Q_SHIFT;
                        quot_next  = '0;
                        neg_next   = b_pos;
                        idx_next   = cur_idx;
                        cnt_next   = DIV_LAST_STEP;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = add_res[DIV_W-1:0];
                end
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                den_next  = den_reg >> 1;
                cnt_next  = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                frac_next  = frac_val;
                pos_next   = POS_PAD_W'(pos_val);
                acc_next   = '0;
                cnt_next   = STEP_W'(DIGITS - 1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // MSB-first digit: acc = acc*256 + digit*period
                acc_next = add_res[ACC_W-1:0];
                pos_next = pos_reg << DIGIT_W;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_frac_next  = frac_reg;
                    out_time_next  = acc_reg[Q_SHIFT +: TIME_W];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, history and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            older_reg     <= '0;
            middle_reg    <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            min_amp_reg   <= MIN_AMP_RST;
            guard_reg     <= GUARD_RST;
            period_reg    <= PERIOD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            older_reg     <= older_next;
            middle_reg    <= middle_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_AMP:       min_amp_reg <= cfg_data[MIN_AMP_W-1:0];
                    CFG_GUARD_SAMPLES: guard_reg   <= cfg_data[GUARD_W-1:0];
                    CFG_SAMPLE_PERIOD: period_reg  <= cfg_data[PERIOD_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quot_reg     <= quot_next;
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        frac_reg     <= frac_next;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        out_idx_reg  <= out_idx_next;
        out_frac_reg <= out_frac_next;
        out_time_reg <= out_time_next;
    end

endmodule

`default_nettype wire
